>>> rtl/core/scasc_pkg.sv
// Shared types, constants and key maps for the scan-code to ASCII queue.
package scasc_pkg;

   localparam int FIFO_DEPTH_DEFAULT = 256;

   localparam int unsigned MAP_LEN = 58;
   localparam logic [7:0] CODE_PREFIX = 8'hE0;
   localparam logic [7:0] CODE_LSHIFT = 8'h2A;
   localparam logic [7:0] CODE_RSHIFT = 8'h36;
   localparam logic [7:0] BREAK_BIT   = 8'h80;
   localparam logic [7:0] CODE_UP     = 8'h48;
   localparam logic [7:0] CODE_DOWN   = 8'h50;
   localparam logic [6:0] CHAR_UP     = 7'h11;
   localparam logic [6:0] CHAR_DOWN   = 7'h12;

   typedef enum logic {
      OP_SCAN = 1'b0,
      OP_POP  = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  scan_byte;
   } req_type;

   typedef struct packed {
      logic        char_valid;
      logic [6:0]  char_out;
      logic        available;
      logic        overflow;
   } rsp_type;

   // Per-word queue status for the result register
   typedef struct packed {
      logic pop_ok;
      logic drop;
      logic avail_next;
   } fifo_status_type;

   // US layout, unshifted
   localparam logic [6:0] PLAIN_MAP [0:MAP_LEN-1] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
      7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
   };

   // US layout, shifted
   localparam logic [6:0] UPPER_MAP [0:MAP_LEN-1] = '{
      7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
      7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
      7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
      7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
      7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
   };

endpackage

>>> rtl/core/scasc_decode.sv
// Key state tracking and scan-code to character lookup.
module scasc_decode (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] code,
   output logic [6:0] char_code
);

   logic shift_held_ff, shift_held_in;
   logic ext_pending_ff, ext_pending_in;
   logic [6:0] char_in;

   always_comb begin
      shift_held_in  = shift_held_ff;
      ext_pending_in = ext_pending_ff;
      char_in        = '0;
      priority if (code == scasc_pkg::CODE_PREFIX) begin
         ext_pending_in = 1'b1;
      end else if (code == scasc_pkg::CODE_LSHIFT || code == scasc_pkg::CODE_RSHIFT) begin
         shift_held_in = 1'b1;
      end else if (code == (scasc_pkg::CODE_LSHIFT | scasc_pkg::BREAK_BIT) ||
                   code == (scasc_pkg::CODE_RSHIFT | scasc_pkg::BREAK_BIT)) begin
         shift_held_in = 1'b0;
      end else if ((code & scasc_pkg::BREAK_BIT) != '0) begin
         ext_pending_in = 1'b0;
      end else if (ext_pending_ff) begin
         ext_pending_in = 1'b0;
         if (code == scasc_pkg::CODE_UP) begin
            char_in = scasc_pkg::CHAR_UP;
         end else if (code == scasc_pkg::CODE_DOWN) begin
            char_in = scasc_pkg::CHAR_DOWN;
         end
      end else if (code < 8'(scasc_pkg::MAP_LEN)) begin
         char_in = shift_held_ff ? scasc_pkg::UPPER_MAP[code[5:0]]
                                 : scasc_pkg::PLAIN_MAP[code[5:0]];
      end
   end

   assign char_code = fire ? char_in : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_held_ff  <= 1'b0;
         ext_pending_ff <= 1'b0;
      end else if (fire) begin
         shift_held_ff  <= shift_held_in;
         ext_pending_ff <= ext_pending_in;
      end
   end

endmodule

>>> rtl/core/scasc_fifo.sv
// Character ring queue with registered read port.
module scasc_fifo #(
   parameter int FIFO_DEPTH = scasc_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        pop_req,
   input  logic [6:0]                  push_char,
   output scasc_pkg::fifo_status_type  status,
   output logic [6:0]                  rd_char_ff
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic [6:0]       mem [0:FIFO_DEPTH-1];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_req, full, push_ok, pop_ok;

   assign push_req = step && !pop_req && (push_char != '0);
   assign full     = (count_ff == CNT_W'(FIFO_DEPTH));
   assign push_ok  = push_req && !full;
   assign pop_ok   = step && pop_req && (count_ff != '0);

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end else if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   assign status.pop_ok     = pop_ok;
   assign status.drop       = push_req && full;
   assign status.avail_next = (count_in != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[wr_ptr_ff] <= push_char;
      end
   end

   // Read data is held while the result word waits
   always_ff @(posedge clock) begin
      if (step) begin
         rd_char_ff <= pop_ok ? mem[rd_ptr_ff] : '0;
      end
   end

endmodule

>>> rtl/core/scancode_to_ascii_fifo.sv
// Top level: scan-code set 1 decoder feeding a character queue.
// Throughput: one word per cycle while rsp_ready drains the response; input register,
//   then decode and queue access in one pass, then the response register (queue read
//   data is registered there).
// Reset (synchronous, active high): clears both stage valids, shift and prefix state
//   and the queue pointers and count. Queue storage is not cleared, no clearing pass.
module scancode_to_ascii_fifo #(
   parameter int FIFO_DEPTH = scasc_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  scasc_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output scasc_pkg::rsp_type  rsp_data
);

   // Input register stage
   logic                s1_valid_ff, s1_valid_in;
   scasc_pkg::req_type  s1_req_ff;

   // Response register stage (char_out lives in the queue read register)
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_char_valid_ff;
   logic                rsp_available_ff;
   logic                rsp_overflow_ff;

   logic                       advance;
   logic                       is_pop;
   logic [6:0]                 dec_char;
   logic [6:0]                 rd_char;
   scasc_pkg::fifo_status_type fifo_status;

   // A word leaves the input stage whenever the response slot is free or being drained
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign is_pop    = (s1_req_ff.opcode == scasc_pkg::OP_POP);

   assign s1_valid_in  = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : ((rsp_valid_ff && rsp_ready) ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff <= req_data;
      end
   end

   // Shift/prefix tracking only moves on scan-code words
   scasc_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance && !is_pop),
      .code      (s1_req_ff.scan_byte),
      .char_code (dec_char)
   );

   scasc_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .pop_req    (is_pop),
      .push_char  (dec_char),
      .status     (fifo_status),
      .rd_char_ff (rd_char)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_char_valid_ff <= fifo_status.pop_ok;
         rsp_available_ff  <= fifo_status.avail_next;
         rsp_overflow_ff   <= fifo_status.drop;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data.char_valid = rsp_char_valid_ff;
   assign rsp_data.char_out   = rd_char;
   assign rsp_data.available  = rsp_available_ff;
   assign rsp_data.overflow   = rsp_overflow_ff;

endmodule

>>> rtl/core/scasc_checker.sv
// Port-level checks for the scan-code to ASCII queue, bound to the top level.
module scasc_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input scasc_pkg::rsp_type  rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.char_valid == (rsp_data.char_out != '0)))
      else $error("char_out disagrees with char_valid");

   a_pop_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.char_valid && rsp_data.overflow))
      else $error("pop word reports overflow");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |-> rsp_data.available)
      else $error("overflow with empty queue");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind scancode_to_ascii_fifo scasc_checker u_checker (.*);
